@@ rtl/ssmsl_pkg.sv @@
// ----------------------------------------------------------------------------
// ssmsl_pkg
// Shared types and constants for the skid-steer mixer with slew limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssmsl_pkg;

  // frame constants
  localparam logic [7:0] CtrlByte = 8'hC3;
  localparam logic [7:0] FillByte = 8'h64;
  localparam logic [7:0] ZeroByte = 8'h00;

  // stick and knob scaling
  localparam int PulseCentre = 1500;
  localparam int DeadBand    = 30;
  localparam int StickScale  = 500;
  localparam int KnobBase    = 1000;
  localparam int KnobScale   = 1000;
  // StickScale * KnobScale
  localparam int DivDen      = StickScale * KnobScale;

  // DivDen = 2^DivShift * DivOdd; the odd part goes through a reciprocal multiply
  localparam int          DivShift   = 5;
  localparam logic [13:0] DivOdd     = 14'd15625;
  // ceil(2^43 / 15625), exact for any 29-bit dividend
  localparam logic [29:0] RecipMul   = 30'd562949954;
  localparam int          RecipShift = 43;

  // register indexes
  localparam logic [1:0] RegMaxSpeed = 2'd0;
  localparam logic [1:0] RegSlewStep = 2'd1;

  localparam logic [14:0] MaxSpeedRst = 15'd1000;
  localparam logic [14:0] SlewStepRst = 15'd100;

  typedef enum logic [2:0] {
    StIdle,
    StScale,
    StMul,
    StRecip,
    StCheck,
    StSlew,
    StDone
  } state_e;

endpackage

@@ rtl/skid_steer_mixer_slew_limiter.sv @@
// ----------------------------------------------------------------------------
// skid_steer_mixer_slew_limiter
// Mixes steering and throttle pulses into left/right motor speeds, slews
// the stored speeds toward their targets and emits an 8-byte motor frame.
// ----------------------------------------------------------------------------
// channel | direction | handshake               | payload
// in      | sink      | in_valid_i / in_stall_o   | steer, throttle, knob pulses
// out     | source    | out_valid_o / out_stall_i | eight frame bytes
// cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A request runs from acceptance to the next acceptance through: one
// multiply for the knob scale, then per side a mix multiply, a reciprocal
// multiply for the divide, a back-multiply for the remainder test and a slew
// step, the multiplies all on the one shared multiplier, then done and idle.
// Reset clears the stored speeds to zero and loads max_speed = 1000,
// slew_step = 100. A stalled result waits in its output register; the
// next request is taken meanwhile and waits at the end if still blocked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skid_steer_mixer_slew_limiter
  import ssmsl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] steer_pulse_i,
  input  logic [11:0] throttle_pulse_i,
  input  logic [11:0] knob_pulse_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_zero_o,
  output logic [7:0]  right_high_o,
  output logic [7:0]  right_low_o,
  output logic [7:0]  byte_three_o,
  output logic [7:0]  left_high_o,
  output logic [7:0]  left_low_o,
  output logic [7:0]  byte_six_o,
  output logic [7:0]  byte_seven_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [9:0] stick_value(input logic [11:0] pulse);
    logic signed [12:0] d;
    logic signed [12:0] band;
    logic signed [12:0] lim;
    d    = $signed({1'b0, pulse}) - $signed(13'(PulseCentre));
    band = $signed(13'(DeadBand));
    lim  = $signed(13'(StickScale));
    if (d <= band && d >= -band) begin
      return '0;
    end else if (d > lim) begin
      return lim[9:0];
    end else if (d < -lim) begin
      return 10'(-lim);
    end
    return d[9:0];
  endfunction

  function automatic logic signed [9:0] clamp_mix(input logic signed [10:0] v);
    logic signed [10:0] lim;
    lim = $signed(11'(StickScale));
    if (v > lim) begin
      return lim[9:0];
    end else if (v < -lim) begin
      return 10'(-lim);
    end
    return v[9:0];
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [14:0]        max_speed_q, slew_step_q;
  logic signed [15:0] left_speed_q, right_speed_q;
  logic signed [9:0]  lmix_q, rmix_q;
  logic [9:0]         mult_q;
  logic [24:0]        scale_q;
  logic [28:0]        nshift_q;
  logic               low_nz_q;
  logic [15:0]        quot_q;
  logic               rem_nz_q;
  logic               side_q;
  logic               out_valid_q;
  logic [15:0]        left_out_q, right_out_q;

  // controls
  logic in_accept, out_accept;
  logic scale_en, mul_en, recip_en, check_en, slew_en, out_load;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // front end: stick, mix and knob decode at acceptance
  // --------------------------------------------------------------------------
  logic signed [9:0]  steer_v, thr_v;
  logic signed [10:0] lsum, rsum;
  logic signed [12:0] knob_off;
  logic [9:0]         mult_v;

  always_comb begin
    steer_v  = stick_value(steer_pulse_i);
    thr_v    = stick_value(throttle_pulse_i);
    lsum     = 11'(thr_v) - 11'(steer_v);
    rsum     = -(11'(thr_v) + 11'(steer_v));
    knob_off = $signed({1'b0, knob_pulse_i}) - $signed(13'(KnobBase));
    if (knob_pulse_i == '0) begin
      mult_v = 10'(KnobScale);
    end else if (knob_off < 0) begin
      mult_v = '0;
    end else if (knob_off > $signed(13'(KnobScale))) begin
      mult_v = 10'(KnobScale);
    end else begin
      mult_v = knob_off[9:0];
    end
  end

  // --------------------------------------------------------------------------
  // shared multiplier
  // --------------------------------------------------------------------------
  logic signed [9:0] mix_sel;
  logic [9:0]        mix_mag;
  logic [28:0]       mul_a;
  logic [29:0]       mul_b;
  logic [58:0]       mul_p;

  assign mix_sel = side_q ? rmix_q : lmix_q;
  assign mix_mag = mix_sel[9] ? (~mix_sel + 10'd1) : mix_sel;

  // divide by 500000: drop 5 low bits, then multiply by the reciprocal of
  // 15625 and check the quotient by multiplying it back
  always_comb begin
    unique case (state_q)
      StScale: begin
        mul_a = {14'd0, max_speed_q};
        mul_b = {20'd0, mult_q};
      end
      StRecip: begin
        mul_a = nshift_q;
        mul_b = RecipMul;
      end
      StCheck: begin
        mul_a = {13'd0, quot_q};
        mul_b = {16'd0, DivOdd};
      end
      default: begin
        mul_a = {4'd0, scale_q};
        mul_b = {20'd0, mix_mag};
      end
    endcase
  end

  assign mul_p = 59'(mul_a) * 59'(mul_b);

  // --------------------------------------------------------------------------
  // floor fix-up and slew
  // --------------------------------------------------------------------------
  logic signed [16:0] tgt;
  logic signed [15:0] cur;
  logic signed [17:0] diff, step18, cur_up, cur_dn;
  logic signed [15:0] slewed;

  always_comb begin
    if (mix_sel[9]) begin
      tgt = $signed(17'd0) - $signed({1'b0, quot_q}) - $signed({16'd0, rem_nz_q});
    end else begin
      tgt = $signed({1'b0, quot_q});
    end
    cur    = side_q ? right_speed_q : left_speed_q;
    step18 = $signed({3'd0, slew_step_q});
    diff   = 18'(tgt) - 18'(cur);
    cur_up = 18'(cur) + step18;
    cur_dn = 18'(cur) - step18;
    priority if (diff > step18) begin
      slewed = cur_up[15:0];
    end else if (diff < -step18) begin
      slewed = cur_dn[15:0];
    end else begin
      slewed = tgt[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i) state_d = StScale;
      StScale: state_d = StMul;
      StMul:   state_d = StRecip;
      StRecip: state_d = StCheck;
      StCheck: state_d = StSlew;
      StSlew:  state_d = side_q ? StDone : StMul;
      StDone:  if (!out_valid_q || !out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    scale_en   = 1'b0;
    mul_en     = 1'b0;
    recip_en   = 1'b0;
    check_en   = 1'b0;
    slew_en    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      StIdle:  in_stall_o = 1'b0;
      StScale: scale_en   = 1'b1;
      StMul:   mul_en     = 1'b1;
      StRecip: recip_en   = 1'b1;
      StCheck: check_en   = 1'b1;
      StSlew:  slew_en    = 1'b1;
      StDone:  out_load   = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      max_speed_q   <= MaxSpeedRst;
      slew_step_q   <= SlewStepRst;
      left_speed_q  <= '0;
      right_speed_q <= '0;
      side_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegMaxSpeed) max_speed_q <= cfg_data_i[14:0];
        if (cfg_index_i == RegSlewStep) slew_step_q <= cfg_data_i[14:0];
      end
      if (in_accept) side_q <= 1'b0;
      if (slew_en) begin
        if (side_q) begin
          right_speed_q <= slewed;
        end else begin
          left_speed_q <= slewed;
        end
        side_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lmix_q <= clamp_mix(lsum);
      rmix_q <= clamp_mix(rsum);
      mult_q <= mult_v;
    end
    if (scale_en) scale_q <= mul_p[24:0];
    if (mul_en) begin
      nshift_q <= mul_p[33:DivShift];
      low_nz_q <= |mul_p[DivShift-1:0];
    end
    if (recip_en) quot_q <= mul_p[RecipShift +: 16];
    // any remainder pushes a negative target one further down
    if (check_en) rem_nz_q <= low_nz_q || (mul_p[28:0] != nshift_q);
    if (out_load) begin
      left_out_q  <= left_speed_q;
      right_out_q <= right_speed_q;
    end
  end

  // --------------------------------------------------------------------------
  // outputs
  // --------------------------------------------------------------------------
  assign out_valid_o  = out_valid_q;
  assign byte_zero_o  = CtrlByte;
  assign right_high_o = right_out_q[15:8];
  assign right_low_o  = right_out_q[7:0];
  assign byte_three_o = FillByte;
  assign left_high_o  = left_out_q[15:8];
  assign left_low_o   = left_out_q[7:0];
  assign byte_six_o   = FillByte;
  assign byte_seven_o = ZeroByte;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == StScale)
    else $error("accepted request did not start the sequencer");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCheck |-> !quot_q[15])
    else $error("quotient out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=>
      out_valid_q && $stable(left_out_q) && $stable(right_out_q))
    else $error("stalled result changed");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StDone)
    else $error("result raised outside the done phase");

endmodule
